[hdl/chained_range_offset_translate_unit_assert.svh]
`ifndef CHAINED_RANGE_OFFSET_TRANSLATE_UNIT_ASSERT_SVH
`define CHAINED_RANGE_OFFSET_TRANSLATE_UNIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is held
`define CROT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("crot: same-cycle check failed");

// Next-cycle implication, ignored while reset is held
`define CROT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("crot: next-cycle check failed");

// Next-cycle implication that also holds across reset
`define CROT_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("crot: reset check failed");

`endif

[hdl/crot_pkg.sv]
package crot_pkg;

    localparam int VALUE_W = 64;
    localparam int STAGE_W = 3;
    localparam int SLOT_W  = 5;
    localparam int CFG_W   = 4;
    localparam int S_TDATA_W = 272;
    localparam int M_TDATA_W = 64;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd7;

    typedef enum logic {
        KIND_WRITE     = 1'b0,
        KIND_TRANSLATE = 1'b1
    } kind_t;

    // One beat travelling down the cell chain. data0 carries the window
    // start for a write and the value being translated otherwise.
    typedef struct packed {
        logic                vld;
        kind_t               kind;
        logic [STAGE_W-1:0]  stage;
        logic [SLOT_W-1:0]   slot;
        logic                en;
        logic [VALUE_W-1:0]  data0;
        logic [VALUE_W-1:0]  len;
        logic [VALUE_W-1:0]  tgt;
        logic                done;
    } beat_t;

endpackage

[hdl/crot_cell.sv]
module crot_cell
    import crot_pkg::*;
#(
    parameter int STAGE_ID = 0,
    parameter int SLOT_ID  = 0
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  advance,
    input  logic  stage_active,
    input  beat_t beat_in,
    output beat_t beat_out
);

    logic               win_valid_reg, win_valid_next;
    logic [VALUE_W-1:0] start_reg;
    logic [VALUE_W-1:0] len_reg;
    logic [VALUE_W-1:0] delta_reg;
    logic               vld_reg;
    beat_t              beat_reg, beat_next;

    logic               done_in;
    logic               wr_hit;
    logic               hit;
    logic [VALUE_W-1:0] off;

    // A new stage starts with no match taken yet
    assign done_in = (SLOT_ID == 0) ? 1'b0 : beat_in.done;

    // Decode a write aimed at this window
    assign wr_hit = beat_in.vld && (beat_in.kind == KIND_WRITE)
                    && (32'(beat_in.stage) == STAGE_ID)
                    && (32'(beat_in.slot) == SLOT_ID);

    // Match: offset into the window below its length, modulo 2^64
    assign off = beat_in.data0 - start_reg;
    assign hit = beat_in.vld && (beat_in.kind == KIND_TRANSLATE) && stage_active
                 && win_valid_reg && !done_in && (off < len_reg);

    // Remap on a hit, pass through otherwise
    always_comb begin
        beat_next      = beat_in;
        beat_next.done = done_in | hit;
        if (hit) begin
            beat_next.data0 = beat_in.data0 + delta_reg;
        end
        win_valid_next = wr_hit ? beat_in.en : win_valid_reg;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= 1'b0;
            win_valid_reg <= 1'b0;
        end else if (advance) begin
            vld_reg       <= beat_in.vld;
            win_valid_reg <= win_valid_next;
        end
    end

    // Window payload and forwarded beat
    always_ff @(posedge aclk) begin
        if (advance) begin
            beat_reg <= beat_next;
            if (wr_hit) begin
                start_reg <= beat_in.data0;
                len_reg   <= beat_in.len;
                delta_reg <= beat_in.tgt - beat_in.data0;
            end
        end
    end

    always_comb begin
        beat_out     = beat_reg;
        beat_out.vld = vld_reg;
    end

endmodule

[hdl/chained_range_offset_translate_unit.sv]
// Chained range-window translator. Every input beat enters a chain of
// STAGE_COUNT * WINDOWS_PER_STAGE cells, one cell per window, in stage order
// and slot order; each cell compares and remaps the passing value against its
// own window and hands the beat on through its register. One beat is taken per
// cycle while the chain advances, and a query's result passes every cell
// register and then the output register. Window writes travel the same
// chain, so every query sees exactly the writes accepted before it. A write
// beat gives no result. The chain holds only while a result waits at the
// output and another is due to leave.
module chained_range_offset_translate_unit
    import crot_pkg::*;
#(
    parameter int STAGE_COUNT       = 8,
    parameter int WINDOWS_PER_STAGE = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // stages_in_use
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [2:0] stage, [7:3] slot, [8] entry_enable, [72:9] window_start,
    // [136:73] window_length, [200:137] window_target, [264:201] query_value
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [0] kind
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [63:0] translated_value
    output logic [M_TDATA_W-1:0]  m_tdata
);

    localparam int CELL_COUNT = STAGE_COUNT * WINDOWS_PER_STAGE;

    logic [CFG_W-1:0]     stages_in_use_reg;
    logic [STAGE_COUNT-1:0] stage_act;
    beat_t                chain [CELL_COUNT+1];
    beat_t                exit_beat;
    logic                 exit_res;
    logic                 advance;
    logic                 out_load;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [VALUE_W-1:0]   m_tdata_reg, m_tdata_next;

    // Hold the stage count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stages_in_use_reg <= CFG_RESET;
        end else if (cfg_we) begin
            stages_in_use_reg <= cfg_wdata;
        end
    end

    // Unpack the incoming beat
    always_comb begin
        chain[0].vld   = s_tvalid;
        chain[0].kind  = kind_t'(s_tuser);
        chain[0].stage = s_tdata[2:0];
        chain[0].slot  = s_tdata[7:3];
        chain[0].en    = s_tdata[8];
        chain[0].data0 = s_tuser ? s_tdata[264:201] : s_tdata[72:9];
        chain[0].len   = s_tdata[136:73];
        chain[0].tgt   = s_tdata[200:137];
        chain[0].done  = 1'b0;
    end

    // Cell row, one cell per window
    for (genvar s = 0; s < STAGE_COUNT; s++) begin : g_stage
        assign stage_act[s] = (32'(stages_in_use_reg) > s);
        for (genvar w = 0; w < WINDOWS_PER_STAGE; w++) begin : g_win
            crot_cell #(
                .STAGE_ID (s),
                .SLOT_ID  (w)
            ) u_cell (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .advance      (advance),
                .stage_active (stage_act[s]),
                .beat_in      (chain[s*WINDOWS_PER_STAGE + w]),
                .beat_out     (chain[s*WINDOWS_PER_STAGE + w + 1])
            );
        end
    end

    // Stall the chain only when a result is due and the output is still full
    assign exit_beat = chain[CELL_COUNT];
    assign exit_res  = exit_beat.vld && (exit_beat.kind == KIND_TRANSLATE);
    assign out_load  = m_tready || !m_tvalid_reg;
    assign advance   = out_load || !exit_res;
    assign s_tready  = advance;

    // Output register next state
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (out_load) begin
            m_tvalid_next = exit_res;
            m_tdata_next  = exit_beat.data0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[hdl/crot_checker.sv]
`include "chained_range_offset_translate_unit_assert.svh"

module crot_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready
);

    // A waiting result stays offered
    `CROT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)

    // Reset empties the output register
    `CROT_ASSERT_NEXT_ALWAYS(a_rst_empty, aclk, !aresetn, !m_tvalid)

    // An empty output never blocks the input
    `CROT_ASSERT_NOW(a_empty_ready, aclk, aresetn, !m_tvalid, s_tready)

    // A draining output never blocks the input
    `CROT_ASSERT_NOW(a_drain_ready, aclk, aresetn, m_tready, s_tready)

endmodule

bind chained_range_offset_translate_unit crot_checker u_crot_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

[verif/crot_translate_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of the translator, keeps its own copy of the window
// tables and the stage count, and checks every result beat against the
// oldest predicted value.
module crot_translate_checker
    import crot_pkg::*;
#(
    parameter int STAGE_COUNT       = 8,
    parameter int WINDOWS_PER_STAGE = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    output int                    mismatch_count,
    output int                    outstanding
);

    logic [CFG_W-1:0]   stages_cfg;
    bit                 win_valid [STAGE_COUNT][WINDOWS_PER_STAGE];
    bit [VALUE_W-1:0]   win_start [STAGE_COUNT][WINDOWS_PER_STAGE];
    bit [VALUE_W-1:0]   win_len   [STAGE_COUNT][WINDOWS_PER_STAGE];
    bit [VALUE_W-1:0]   win_tgt   [STAGE_COUNT][WINDOWS_PER_STAGE];
    logic [VALUE_W-1:0] pending_values [$];

    // Pass a value through every stage in use; first matching slot wins
    function automatic logic [VALUE_W-1:0] translate_chain(input logic [VALUE_W-1:0] value);
        int                 active;
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] off;
        bit                 hit;
        active = (stages_cfg > STAGE_COUNT) ? STAGE_COUNT : int'(stages_cfg);
        v = value;
        for (int st = 0; st < active; st++) begin
            hit = 1'b0;
            for (int w = 0; w < WINDOWS_PER_STAGE && !hit; w++) begin
                // modular match, so windows running past the top wrap through zero
                off = v - win_start[st][w];
                if (win_valid[st][w] && off < win_len[st][w]) begin
                    v   = win_tgt[st][w] + off;
                    hit = 1'b1;
                end
            end
        end
        return v;
    endfunction

    always @(posedge aclk) begin : monitor
        int                 errors;
        int                 st;
        int                 sl;
        logic [VALUE_W-1:0] want;
        errors = 0;
        if (!aresetn) begin
            stages_cfg = CFG_RESET;
            foreach (win_valid[i, j]) win_valid[i][j] = 1'b0;
            pending_values.delete();
            mismatch_count <= 0;
            outstanding    <= 0;
        end else begin
            // compare the result beat with the oldest prediction
            if (m_tvalid && m_tready) begin
                if (pending_values.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got %h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    want = pending_values.pop_front();
                    if (m_tdata !== want) begin
                        $display("%0t: translated_value mismatch, expected %h, got %h",
                                 $time, want, m_tdata);
                        errors++;
                    end
                end
            end

            if (cfg_we)
                stages_cfg = cfg_wdata;

            // update the tables or queue a prediction for each input beat
            if (s_tvalid && s_tready) begin
                if (kind_t'(s_tuser) == KIND_WRITE) begin
                    st = int'(s_tdata[2:0]);
                    sl = int'(s_tdata[7:3]);
                    if (st < STAGE_COUNT && sl < WINDOWS_PER_STAGE) begin
                        win_valid[st][sl] = s_tdata[8];
                        win_start[st][sl] = s_tdata[72:9];
                        win_len[st][sl]   = s_tdata[136:73];
                        win_tgt[st][sl]   = s_tdata[200:137];
                    end
                end else begin
                    pending_values.insert(pending_values.size(),
                                          translate_chain(s_tdata[264:201]));
                end
            end

            mismatch_count <= mismatch_count + errors;
            outstanding    <= pending_values.size();
        end
    end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import crot_pkg::*;

    localparam int STAGE_COUNT       = 8;
    localparam int WINDOWS_PER_STAGE = 32;
    // chain depth plus some margin for the last beats to clear
    localparam int CHAIN_DRAIN       = STAGE_COUNT * WINDOWS_PER_STAGE + 40;
    localparam int ROUNDS            = 8;
    localparam int HOLD_CYCLES       = 800;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    int                    mismatch_count;
    int                    outstanding;
    int                    send_gap_pct  = 0;
    int                    rx_stall_pct  = 0;
    logic                  rx_hold       = 1'b0;
    logic [VALUE_W-1:0]    anchor_pool [8];
    logic [CFG_W-1:0]      stage_settings [ROUNDS];

    chained_range_offset_translate_unit #(
        .STAGE_COUNT       (STAGE_COUNT),
        .WINDOWS_PER_STAGE (WINDOWS_PER_STAGE)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    crot_translate_checker #(
        .STAGE_COUNT       (STAGE_COUNT),
        .WINDOWS_PER_STAGE (WINDOWS_PER_STAGE)
    ) checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Backstop in case the block locks up
    initial begin
        #2_000_000;
        $display("** chained_range_offset_translate_unit: FAILED **");
        $finish;
    end

    // Result side: random stalls, plus the long hold-off when asked
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Values clustered round a few anchors so windows and queries meet often
    function automatic logic [63:0] pick_value();
        case ($urandom_range(9))
            6:       return anchor_pool[$urandom_range(7)] - 64'($urandom_range(255));
            7:       return rand64();
            8:       return '1;
            9:       return '0;
            default: return anchor_pool[$urandom_range(7)] + 64'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [63:0] pick_length();
        case ($urandom_range(9))
            5:       return '0;
            6:       return '1;
            7:       return rand64();
            8:       return 64'd1;
            9:       return 64'($urandom_range(4096, 256));
            default: return 64'($urandom_range(300, 1));
        endcase
    endfunction

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_gap_pct = 0;  rx_stall_pct = 0;  end
            IDLE_SENDER:   begin send_gap_pct = 46; rx_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_gap_pct = 0;  rx_stall_pct = 46; end
            default:       begin send_gap_pct = 37; rx_stall_pct = 37; end
        endcase
    endtask

    // Offer one beat, with an optional gap first, and hold until accepted
    task automatic send_beat(input kind_t kind, input logic [STAGE_W-1:0] stage,
                             input logic [SLOT_W-1:0] slot, input logic en,
                             input logic [VALUE_W-1:0] start, input logic [VALUE_W-1:0] len,
                             input logic [VALUE_W-1:0] tgt, input logic [VALUE_W-1:0] query);
        if ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'b0, query, tgt, len, start, en, slot, stage};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_window(input logic [STAGE_W-1:0] stage, input logic [SLOT_W-1:0] slot,
                                input logic en, input logic [VALUE_W-1:0] start,
                                input logic [VALUE_W-1:0] len, input logic [VALUE_W-1:0] tgt);
        send_beat(KIND_WRITE, stage, slot, en, start, len, tgt, rand64());
    endtask

    // Window fields of a query beat carry noise
    task automatic query(input logic [VALUE_W-1:0] value);
        send_beat(KIND_TRANSLATE, STAGE_W'($urandom_range(7)), SLOT_W'($urandom_range(31)),
                  1'($urandom_range(1)), rand64(), rand64(), rand64(), value);
    endtask

    task automatic send_random_beat();
        if ($urandom_range(99) < 35)
            write_window(STAGE_W'($urandom_range(7)),
                         SLOT_W'(($urandom_range(9) < 7) ? $urandom_range(7)
                                                         : $urandom_range(31)),
                         $urandom_range(9) != 0, pick_value(), pick_length(), pick_value());
        else
            query(pick_value());
    endtask

    // Drop valid, wait for every result, then let trailing writes leave the chain
    task automatic drain_chain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (CHAIN_DRAIN) @(posedge aclk);
    endtask

    task automatic write_stages(input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        anchor_pool[0] = '0;
        anchor_pool[1] = 64'hFFFF_FFFF_FFFF_FF00;
        anchor_pool[2] = 64'h8000_0000_0000_0000;
        anchor_pool[3] = 64'h0000_0000_0000_1000;
        for (int i = 4; i < 8; i++) anchor_pool[i] = rand64();
        stage_settings = '{4'd8, 4'd15, 4'd1, 4'd0, 4'd7, 4'd4, 4'd0, 4'd8};
        stage_settings[6] = CFG_W'($urandom_range(15));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, stage count at its reset value
        query('0);
        query('1);
        write_window(3'd0, 5'd0, 1'b1, 64'd100, 64'd10, 64'd1000);
        query(64'd100);
        query(64'd109);
        query(64'd110);
        query(64'd99);
        // overlapping window in a lower-priority slot
        write_window(3'd0, 5'd1, 1'b1, 64'd95, 64'd20, 64'd5000);
        query(64'd105);
        query(64'd97);
        // window wrapping through zero
        write_window(3'd1, 5'd31, 1'b1, 64'hFFFF_FFFF_FFFF_FFF0, 64'h20, 64'h10);
        query(64'hFFFF_FFFF_FFFF_FFF8);
        query(64'd5);
        // invalidate slot 0, slot 1 takes over
        write_window(3'd0, 5'd0, 1'b0, 64'd100, 64'd10, 64'd1000);
        query(64'd100);
        // empty window never matches
        write_window(3'd2, 5'd3, 1'b1, 64'd7, 64'd0, 64'd99);
        query(64'd7);
        // window covering all but the top value
        write_window(3'd6, 5'd31, 1'b1, 64'd0, '1, 64'd1);
        query(64'd123456);
        query('1);
        // stage beyond those in use must have no effect
        write_window(3'd7, 5'd0, 1'b1, 64'd0, '1, 64'd2);
        query(64'd42);
        write_window(3'd6, 5'd31, 1'b0, '0, '0, '0);
        query(64'd1000);
        write_window(3'd7, 5'd0, 1'b0, '0, '0, '0);

        // Random rounds, each with its own stage count and idling pattern
        for (int r = 0; r < ROUNDS; r++) begin
            drain_chain();
            write_stages(stage_settings[r]);
            set_idle(idle_mode_t'(r % 4));
            if (r == 0) begin
                // hold the receiver off long enough for the chain to back up
                fork
                    begin
                        rx_hold <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge aclk);
                        rx_hold <= 1'b0;
                    end
                join_none
            end
            repeat ((r == 0) ? 300 : 45) send_random_beat();
        end
        drain_chain();

        if (mismatch_count == 0 && outstanding == 0)
            $display("** chained_range_offset_translate_unit: PASSED **");
        else
            $display("** chained_range_offset_translate_unit: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/crot_pkg.sv
hdl/crot_cell.sv
hdl/chained_range_offset_translate_unit.sv
hdl/crot_checker.sv
verif/crot_translate_checker.sv
verif/tb_top.sv
